### rtl/hted_pkg.sv
// Package for the humidity/temperature edge decoder: codes, constants and the
// types passed between the frame tracker, the converter and the top level.
// No dependencies.
package hted_pkg;

    localparam int FRAME_BITS = 40;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_EDGE    = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_HEADER   = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    localparam logic REG_SENSOR_KIND   = 1'b0;
    localparam logic REG_BIT_THRESHOLD = 1'b1;

    localparam logic        SENSOR_KIND_RST   = 1'b1;
    localparam logic [15:0] BIT_THRESHOLD_RST = 16'd100;

    localparam logic [15:0] HEADER_MIN      = 16'd120;
    localparam logic [5:0]  EDGES_PER_FRAME = 6'd42;

    typedef struct packed {
        logic                  emit;
        logic                  timeout;
        logic                  header_bad;
        logic [FRAME_BITS-1:0] raw;
    } frame_evt_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [15:0]           humidity_tenths;
        logic signed [15:0]    temperature_tenths;
        logic [FRAME_BITS-1:0] raw_frame;
    } result_t;

endpackage

### rtl/hted_frame.sv
// Frame tracker: holds the per-frame state and collects the data bits from
// edge-to-edge periods. Depends on hted_pkg.
module hted_frame
    import hted_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [1:0]  action,
    input  logic [15:0] stamp,
    input  logic [15:0] bit_threshold,
    output frame_evt_t  evt
);

    logic                  active_reg, active_next;
    logic [5:0]            count_reg, count_next;
    logic [15:0]           last_reg, last_next;
    logic                  hbad_reg, hbad_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [15:0]           period;
    logic [5:0]            count_inc;

    assign period    = stamp - last_reg;
    assign count_inc = count_reg + 6'd1;

    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        hbad_next   = hbad_reg;
        shift_next  = shift_reg;
        evt         = '0;
        if (step)
        begin
            if (action == ACT_START)
            begin
                active_next = 1'b1;
                count_next  = '0;
                hbad_next   = 1'b0;
                shift_next  = '0;
            end
            else if (action == ACT_TIMEOUT && active_reg)
            begin
                active_next = 1'b0;
                evt.emit    = 1'b1;
                evt.timeout = 1'b1;
            end
            else if (action == ACT_EDGE && active_reg)
            begin
                if (count_reg == 6'd1)
                begin
                    hbad_next = (period < HEADER_MIN);
                end
                else if (count_reg >= 6'd2)
                begin
                    shift_next = {shift_reg[FRAME_BITS-2:0], (period > bit_threshold)};
                end
                last_next  = stamp;
                count_next = count_inc;
                if (count_inc >= EDGES_PER_FRAME)
                begin
                    active_next = 1'b0;
                    evt.emit    = 1'b1;
                end
            end
        end
        evt.header_bad = hbad_next;
        evt.raw        = shift_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
            last_reg   <= '0;
            hbad_reg   <= 1'b0;
            shift_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
            hbad_reg   <= hbad_next;
            shift_reg  <= shift_next;
        end
    end

endmodule

### rtl/hted_convert.sv
// Result builder: checksum test and conversion of the frame bytes to tenths
// for either sensor format. Depends on hted_pkg.
module hted_convert
    import hted_pkg::*;
(
    input  frame_evt_t evt,
    input  logic       sensor_kind,
    output result_t    res
);

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum;
    logic [15:0] hum_int, tmp_int, mag;

    assign b0 = evt.raw[39:32];
    assign b1 = evt.raw[31:24];
    assign b2 = evt.raw[23:16];
    assign b3 = evt.raw[15:8];
    assign b4 = evt.raw[7:0];
    assign sum = b0 + b1 + b2 + b3;

    assign hum_int = {5'd0, b0, 3'd0} + {7'd0, b0, 1'b0} + {8'd0, b1};
    assign tmp_int = {5'd0, b2, 3'd0} + {7'd0, b2, 1'b0} + {12'd0, b3[3:0]};
    assign mag     = {1'b0, b2[6:0], b3};

    always_comb
    begin
        res.status             = ST_OK;
        res.humidity_tenths    = '0;
        res.temperature_tenths = '0;
        res.raw_frame          = evt.raw;
        priority if (evt.timeout)
        begin
            res.status    = ST_TIMEOUT;
            res.raw_frame = '0;
        end
        else if (evt.header_bad)
        begin
            res.status = ST_HEADER;
        end
        else if (sum != b4)
        begin
            res.status = ST_CHECKSUM;
        end
        else if (!sensor_kind)
        begin
            res.humidity_tenths    = hum_int;
            res.temperature_tenths = tmp_int;
        end
        else
        begin
            res.humidity_tenths    = {b0, b1};
            res.temperature_tenths = b2[7] ? (16'd0 - mag) : mag;
        end
    end

endmodule

### rtl/humidity_temp_edge_decoder_core.sv
// Top level of the humidity/temperature edge decoder: input register, frame
// tracker, converter and result register. Depends on hted_pkg, hted_frame, hted_convert.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser = action, tdata = stamp
//  m_axis    out        tuser = status, tdata = humidity, temperature, raw frame
//  cfg       in         index 0 sensor_kind, index 1 bit_threshold
//
// One transaction per cycle sustained while m_axis is not stalled; a result reaches m_axis
// through the input register, then the result register.
// Frame state updates in the cycle an item leaves the input register.
// Reset clears frame state; sensor_kind resets to 1, bit_threshold to 100.
// A stalled m_axis holds the result; s_axis stalls only while both registers are full.
module humidity_temp_edge_decoder_core
    import hted_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] stamp
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths,
                                        // [71:32] raw_frame
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic        kind_reg;
    logic [15:0] thresh_reg;
    logic        in_valid_reg;
    logic [1:0]  in_action_reg;
    logic [15:0] in_stamp_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_load;
    logic        adv;
    frame_evt_t  evt;
    result_t     res;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign adv           = in_valid_reg && out_load;
    assign s_axis_tready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= SENSOR_KIND_RST;
            thresh_reg <= BIT_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SENSOR_KIND:   kind_reg   <= cfg_data[0];
                REG_BIT_THRESHOLD: thresh_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= s_axis_tuser;
            in_stamp_reg  <= s_axis_tdata;
        end
    end

    hted_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (adv),
        .action        (in_action_reg),
        .stamp         (in_stamp_reg),
        .bit_threshold (thresh_reg),
        .evt           (evt)
    );

    hted_convert u_convert (
        .evt         (evt),
        .sensor_kind (kind_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= adv && evt.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && adv && evt.emit)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {out_reg.raw_frame, out_reg.temperature_tenths,
                            out_reg.humidity_tenths};

endmodule

### rtl/hted_checker.sv
// Port-level checker for the humidity/temperature edge decoder, bound to the
// top level. Depends on hted_pkg.
module hted_checker
    import hted_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled result");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_TIMEOUT |-> m_axis_tdata == 72'd0)
        else $error("timeout result carries data");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_HEADER || m_axis_tuser == ST_CHECKSUM)
            |-> m_axis_tdata[31:0] == 32'd0)
        else $error("failed frame carries readings");

endmodule

bind humidity_temp_edge_decoder_core hted_checker u_hted_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### verif/tb_humidity_temp_edge_decoder_core.sv
// Self-checking testbench for humidity_temp_edge_decoder_core: drives sensor frames
// as edge timestamps and checks each decoded reading against an in-bench predictor.
// Depends on hted_pkg and the decoder RTL.
module tb_humidity_temp_edge_decoder_core;
    import hted_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int ITEM_TARGET = 1150;
    localparam int STALL_LIMIT = 2000;
    localparam int FRAME_EDGES = int'(EDGES_PER_FRAME);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    logic        no_idle = 1'b0;
    int          items_sent = 0;
    int          mismatches = 0;
    result_t     pending_readings[$];

    // predictor copy of the decoder state and registers
    logic        frm_open = 1'b0;
    logic [5:0]  edges_seen = '0;
    logic [15:0] prev_stamp = '0;
    logic        hdr_short = 1'b0;
    logic [39:0] bit_acc = '0;
    logic        kind_r = SENSOR_KIND_RST;
    logic [15:0] thresh_r = BIT_THRESHOLD_RST;

    humidity_temp_edge_decoder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 18);
    end

    task automatic predict_reading(input logic [1:0] action, input logic [15:0] stamp);
        logic [15:0] period;
        logic [7:0]  b0, b1, b2, b3, b4;
        logic [15:0] mag;
        result_t     r;
        r = '0;
        if (action == ACT_START)
        begin
            frm_open   = 1'b1;
            edges_seen = '0;
            hdr_short  = 1'b0;
            bit_acc    = '0;
        end
        else if (action == ACT_TIMEOUT && frm_open)
        begin
            frm_open = 1'b0;
            r.status = ST_TIMEOUT;
            pending_readings.push_back(r);
        end
        else if (action == ACT_EDGE && frm_open)
        begin
            period = stamp - prev_stamp;
            if (edges_seen == 6'd1)
                hdr_short = period < HEADER_MIN;
            else if (edges_seen >= 6'd2)
                bit_acc = {bit_acc[38:0], period > thresh_r};
            prev_stamp = stamp;
            edges_seen = edges_seen + 6'd1;
            if (edges_seen >= EDGES_PER_FRAME)
            begin
                frm_open = 1'b0;
                {b0, b1, b2, b3, b4} = bit_acc;
                r.raw_frame = bit_acc;
                if (hdr_short)
                    r.status = ST_HEADER;
                else if (8'(b0 + b1 + b2 + b3) != b4)
                    r.status = ST_CHECKSUM;
                else
                begin
                    r.status = ST_OK;
                    if (!kind_r)
                    begin
                        r.humidity_tenths    = 16'(b0) * 16'd10 + 16'(b1);
                        r.temperature_tenths = 16'(b2) * 16'd10 + 16'(b3[3:0]);
                    end
                    else
                    begin
                        mag = {1'b0, b2[6:0], b3};
                        r.humidity_tenths    = {b0, b1};
                        r.temperature_tenths = b2[7] ? 16'h0000 - mag : mag;
                    end
                end
                pending_readings.push_back(r);
            end
        end
    endtask

    task automatic push_sample(input logic [1:0] action, input logic [15:0] stamp);
        if (!no_idle && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= stamp;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
        predict_reading(action, stamp);
    endtask

    // drop the stream and let every in-flight transaction retire
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] value);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SENSOR_KIND)
            kind_r = value[0];
        else
            thresh_r = value;
    endtask

    function automatic logic [39:0] frame_bits(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3,
                                              input logic corrupt);
        logic [7:0] sum;
        sum = b0 + b1 + b2 + b3;
        if (corrupt)
            sum = sum + 8'($urandom_range(255, 1));
        return {b0, b1, b2, b3, sum};
    endfunction

    function automatic logic [15:0] bit_period(input logic one);
        int unsigned th;
        int unsigned lim;
        int          roll;
        th   = {16'd0, thresh_r};
        roll = $urandom_range(99);
        if (one)
        begin
            if (th == 65535)
                return 16'($urandom);
            if (roll < 20)
                return 16'(th + 1);
            if (roll < 30)
                return 16'hFFFF;
            lim = (th + 120 > 65535) ? 65535 : th + 120;
            return 16'($urandom_range(lim, th + 1));
        end
        if (roll < 20)
            return 16'(th);
        if (roll < 30)
            return 16'h0000;
        lim = (th > 120) ? th - 120 : 0;
        return 16'($urandom_range(th, lim));
    endfunction

    task automatic send_frame(input logic [39:0] bits, input logic [15:0] hdr_gap,
                              input logic [15:0] first_stamp, input int n_edges);
        logic [15:0] t;
        t = first_stamp;
        push_sample(ACT_START, 16'($urandom));
        for (int e = 0; e < n_edges; e++)
        begin
            if (e == 1)
                t = t + hdr_gap;
            else if (e >= 2)
                t = t + bit_period(bits[41 - e]);
            push_sample(ACT_EDGE, t);
        end
    endtask

    task automatic random_frame(input int n_edges);
        logic [15:0] gap;
        logic [39:0] bits;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 15)
            gap = 16'($urandom_range(119, 0));
        else if (roll < 25)
            gap = 16'($urandom_range(65535, 120));
        else
            gap = 16'($urandom_range(200, 120));
        roll = $urandom_range(99);
        if (roll < 8)
            bits = frame_bits(8'hFF, 8'hFF, 8'hFF, 8'hFF, $urandom_range(99) < 20);
        else if (roll < 12)
            bits = frame_bits(8'h00, 8'h00, 8'h00, 8'h00, $urandom_range(99) < 20);
        else
            bits = frame_bits(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              $urandom_range(99) < 20);
        send_frame(bits, gap, 16'($urandom), n_edges);
    endtask

    task automatic test_reset_defaults();
        // 65.2 %, -10.1 degrees on the tenths format
        send_frame(frame_bits(8'h02, 8'h8C, 8'h80, 8'h65, 1'b0), 16'd160, 16'h1000,
                   FRAME_EDGES);
    endtask

    task automatic test_frame_control();
        push_sample(ACT_RESERVED, 16'hFFFF);
        push_sample(ACT_EDGE, 16'h0000);
        push_sample(ACT_TIMEOUT, 16'hFFFF);
        push_sample(ACT_START, 16'h0000);
        push_sample(ACT_START, 16'hFFFF);
        push_sample(ACT_EDGE, 16'hFFFF);
        push_sample(ACT_EDGE, 16'h0077);
        push_sample(ACT_TIMEOUT, 16'h0000);
        push_sample(ACT_EDGE, 16'h1234);
        push_sample(ACT_RESERVED, 16'h0000);
        // header one tick short, then exactly on the limit with a bad checksum
        send_frame(frame_bits(8'h37, 8'h00, 8'h1A, 8'h05, 1'b0), 16'd119, 16'hFF80,
                   FRAME_EDGES);
        send_frame(frame_bits(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 16'd120, 16'h0000,
                   FRAME_EDGES);
    endtask

    task automatic test_threshold_extremes();
        cfg_write(REG_SENSOR_KIND, {15'($urandom), 1'b0});
        cfg_write(REG_BIT_THRESHOLD, 16'h0000);
        send_frame(frame_bits(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0), 16'hFFFF, 16'hFFF0,
                   FRAME_EDGES);
        cfg_write(REG_BIT_THRESHOLD, 16'hFFFF);
        send_frame(frame_bits(8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 16'd200, 16'h8000,
                   FRAME_EDGES);
        cfg_write(REG_SENSOR_KIND, {15'($urandom), 1'b1});
        cfg_write(REG_BIT_THRESHOLD, 16'd100);
        // negative zero, then the largest negative magnitude
        send_frame(frame_bits(8'h03, 8'hE8, 8'h80, 8'h00, 1'b0), 16'd140, 16'h0100,
                   FRAME_EDGES);
        send_frame(frame_bits(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0), 16'd140, 16'h7FF0,
                   FRAME_EDGES);
    endtask

    task automatic test_back_to_back();
        cfg_write(REG_BIT_THRESHOLD, 16'd60);
        no_idle = 1'b1;
        repeat (3) random_frame(FRAME_EDGES);
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int          seq;
        int          roll;
        logic [15:0] th;
        seq = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (seq % 5 == 0)
            begin
                case ($urandom_range(5))
                    0:       th = 16'h0000;
                    1:       th = 16'hFFFF;
                    2:       th = 16'd100;
                    3:       th = 16'($urandom_range(200, 30));
                    4:       th = 16'($urandom);
                    default: th = 16'($urandom_range(1000, 300));
                endcase
                cfg_write(REG_SENSOR_KIND, 16'($urandom));
                cfg_write(REG_BIT_THRESHOLD, th);
            end
            roll = $urandom_range(99);
            if (roll < 70)
                random_frame(FRAME_EDGES);
            else if (roll < 85)
            begin
                random_frame($urandom_range(41, 1));
                if ($urandom_range(1))
                    push_sample(ACT_TIMEOUT, 16'($urandom));
                else
                    push_sample(ACT_START, 16'($urandom));
            end
            else
                repeat ($urandom_range(3, 1)) push_sample(2'($urandom), 16'($urandom));
            seq++;
        end
    endtask

    always @(posedge clk)
    begin : reading_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status             = m_axis_tuser;
            got.humidity_tenths    = m_axis_tdata[15:0];
            got.temperature_tenths = m_axis_tdata[31:16];
            got.raw_frame          = m_axis_tdata[71:32];
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reading: status %0d hum %h temp %h raw %h",
                             got.status, got.humidity_tenths, got.temperature_tenths,
                             got.raw_frame);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.status !== want.status
                    || got.humidity_tenths !== want.humidity_tenths
                    || got.temperature_tenths !== want.temperature_tenths
                    || got.raw_frame !== want.raw_frame)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reading mismatch: exp %0d/%h/%h/%h, got %0d/%h/%h/%h",
                                 want.status, want.humidity_tenths, want.temperature_tenths,
                                 want.raw_frame, got.status, got.humidity_tenths,
                                 got.temperature_tenths, got.raw_frame);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_frame_control();
        test_threshold_extremes();
        test_back_to_back();
        test_random_traffic();
        settle_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
